// ===== rtl/core/utf8_text_sanitizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// utf8_text_sanitizer_top_macros.svh
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_SANITIZER_TOP_MACROS_SVH
`define UTF8_TEXT_SANITIZER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define UTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uts check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define UTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uts check failed");

`endif

// ===== rtl/core/uts_pkg.sv =====
// ----------------------------------------------------------------------------
// uts_pkg
// Types, constants and helpers of the UTF-8 text sanitizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uts_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned CODE_W     = 21;

  localparam logic [CNT_W-1:0] CNT_MAX       = 9'd511;
  localparam logic [7:0]       LIMIT_RESET   = 8'd160;
  localparam logic [3:0]       INV_LEN       = 4'd9;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_LBRK  = 7'h5B;
  localparam logic [6:0] CH_RBRK  = 7'h5D;
  localparam logic [6:0] CH_U     = 7'h55;
  localparam logic [6:0] CH_PLUS  = 7'h2B;

  localparam logic [CODE_W-1:0] CP_TIMES = 21'h0000D7;

  typedef enum logic [1:0] {
    BODY_NONE = 2'd0,
    BODY_CHAR = 2'd1,
    BODY_CODE = 2'd2,
    BODY_INV  = 2'd3
  } body_e;

  typedef struct packed {
    logic              inv_pre;
    body_e             body;
    logic [6:0]        chr;
    logic [CODE_W-1:0] code;
  } uts_cmd_t;

  // hex digits printed for a code point: four to six
  function automatic logic [2:0] code_digits(input logic [CODE_W-1:0] cp);
    logic [2:0] d;
    d = 3'd4;
    if (cp[20]) begin
      d = 3'd6;
    end else if (cp[19:16] != 4'd0) begin
      d = 3'd5;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/uts_fifo.sv =====
// ----------------------------------------------------------------------------
// uts_fifo
// Short command queue between the classifier and the expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uts_fifo
  import uts_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire uts_cmd_t data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output uts_cmd_t      data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  uts_cmd_t         mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/uts_front.sv =====
// ----------------------------------------------------------------------------
// uts_front
// Decodes one byte per cycle while accept_i is high, tracks the UTF-8 sequence
// and output count, and issues one expansion command per byte that produces output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uts_front
  import uts_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_string_i,
  output logic            cmd_valid_o,
  output uts_cmd_t        cmd_o
);

  logic [7:0]        limit_q;
  logic [1:0]        exp_q, exp_d;
  logic [1:0]        seen_q, seen_d;
  logic [CODE_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              pending, is_cont, broken, start_en;
  logic [CODE_W-1:0] acc_new;
  logic [1:0]        seen_new;
  logic [9:0]        base;
  logic [3:0]        body_len;
  logic [10:0]       total;
  logic [1:0]        need;
  logic [CODE_W-1:0] lead_cp;
  uts_cmd_t          cmd;

  assign pending  = (exp_q != 2'd0);
  assign is_cont  = (in_byte_i[7:6] == 2'b10);
  assign broken   = pending && !is_cont;
  assign start_en = !pending || broken;
  assign base     = {1'b0, cnt_q} + (broken ? {6'd0, INV_LEN} : 10'd0);
  assign acc_new  = {acc_q[CODE_W-7:0], in_byte_i[5:0]};
  assign seen_new = seen_q + 2'd1;

  always_comb begin
    need    = 2'd0;
    lead_cp = '0;
    if (in_byte_i[7:5] == 3'b110) begin
      need    = 2'd1;
      lead_cp = {16'd0, in_byte_i[4:0]};
    end else if (in_byte_i[7:4] == 4'b1110) begin
      need    = 2'd2;
      lead_cp = {17'd0, in_byte_i[3:0]};
    end else if (in_byte_i[7:3] == 5'b11110) begin
      need    = 2'd3;
      lead_cp = {18'd0, in_byte_i[2:0]};
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.body    = BODY_NONE;
    exp_d       = exp_q;
    seen_d      = seen_q;
    acc_d       = acc_q;
    cmd.inv_pre = broken;

    if (pending && is_cont) begin
      if (seen_new >= exp_q) begin
        if (exp_q == 2'd1 && acc_new == CP_TIMES) begin
          cmd.body = BODY_CHAR;
          cmd.chr  = CH_X;
        end else begin
          cmd.body = BODY_CODE;
          cmd.code = acc_new;
        end
        exp_d  = '0;
        seen_d = '0;
        acc_d  = '0;
      end else if (end_of_string_i) begin
        cmd.body = BODY_INV;
      end else begin
        seen_d = seen_new;
        acc_d  = acc_new;
      end
    end

    if (broken) begin
      exp_d  = '0;
      seen_d = '0;
      acc_d  = '0;
    end

    if (start_en && (base < {2'd0, limit_q})) begin
      if (in_byte_i >= 8'd32 && in_byte_i <= 8'd126) begin
        cmd.body = BODY_CHAR;
        cmd.chr  = in_byte_i[6:0];
      end else if (in_byte_i < 8'd32) begin
        cmd.body = BODY_CHAR;
        cmd.chr  = CH_SPACE;
      end else if (is_cont) begin
        cmd.body = BODY_NONE;
      end else if (need == 2'd0 || end_of_string_i) begin
        cmd.body = BODY_INV;
      end else begin
        exp_d  = need;
        seen_d = '0;
        acc_d  = lead_cp;
      end
    end

    if (end_of_string_i) begin
      exp_d  = '0;
      seen_d = '0;
      acc_d  = '0;
    end
  end

  always_comb begin
    case (cmd.body)
      BODY_CHAR: body_len = 4'd1;
      BODY_INV:  body_len = INV_LEN;
      BODY_CODE: body_len = 4'd4 + {1'b0, code_digits(cmd.code)};
      default:   body_len = 4'd0;
    endcase
    total = {1'b0, base} + {7'd0, body_len};
    if (end_of_string_i) begin
      cnt_d = '0;
    end else if (total > {2'd0, CNT_MAX}) begin
      cnt_d = CNT_MAX;
    end else begin
      cnt_d = total[CNT_W-1:0];
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && (cmd.inv_pre || cmd.body != BODY_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      exp_q   <= '0;
      seen_q  <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (accept_i) begin
        exp_q  <= exp_d;
        seen_q <= seen_d;
        acc_q  <= acc_d;
        cnt_q  <= cnt_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/uts_back.sv =====
// ----------------------------------------------------------------------------
// uts_back
// Expands the queue head into characters, one per cycle while pop_i is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uts_back
  import uts_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     head_valid_i,
  input  wire uts_cmd_t head_i,
  output logic          head_pop_o,
  input  wire logic     pop_i,
  output logic [6:0]    out_char_o,
  output logic          run_last_o
);

  function automatic logic [6:0] inv_char(input logic [3:0] p);
    logic [6:0] ch;
    case (p)
      4'd0:    ch = CH_LBRK;
      4'd1:    ch = 7'h69;
      4'd2:    ch = 7'h6E;
      4'd3:    ch = 7'h76;
      4'd4:    ch = 7'h61;
      4'd5:    ch = 7'h6C;
      4'd6:    ch = 7'h69;
      4'd7:    ch = 7'h64;
      default: ch = CH_RBRK;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] ch;
    if (n < 4'd10) begin
      ch = 7'h30 + {3'd0, n};
    end else begin
      ch = 7'h37 + {3'd0, n};
    end
    return ch;
  endfunction

  logic [3:0]  pos_q, pos_d;
  logic        pre_done_q, pre_done_d;
  logic        in_pre, seg_last, take;
  logic [2:0]  digits;
  logic [3:0]  seg_len;
  logic [3:0]  nib_idx;
  logic [3:0]  nibble;
  logic [23:0] code_ext;
  logic [6:0]  code_ch;

  assign in_pre   = head_i.inv_pre && !pre_done_q;
  assign digits   = code_digits(head_i.code);
  assign code_ext = {3'd0, head_i.code};

  always_comb begin
    if (in_pre) begin
      seg_len = INV_LEN;
    end else begin
      case (head_i.body)
        BODY_INV:  seg_len = INV_LEN;
        BODY_CODE: seg_len = 4'd4 + {1'b0, digits};
        default:   seg_len = 4'd1;
      endcase
    end
  end

  assign seg_last   = (pos_q == seg_len - 4'd1);
  assign run_last_o = seg_last && (!in_pre || head_i.body == BODY_NONE);

  // digit index counts down from the most significant printed nibble
  assign nib_idx = {1'b0, digits} + 4'd2 - pos_q;

  always_comb begin
    case (nib_idx)
      4'd0:    nibble = code_ext[3:0];
      4'd1:    nibble = code_ext[7:4];
      4'd2:    nibble = code_ext[11:8];
      4'd3:    nibble = code_ext[15:12];
      4'd4:    nibble = code_ext[19:16];
      default: nibble = code_ext[23:20];
    endcase
    case (pos_q)
      4'd0:    code_ch = CH_LBRK;
      4'd1:    code_ch = CH_U;
      4'd2:    code_ch = CH_PLUS;
      default: code_ch = seg_last ? CH_RBRK : hex_char(nibble);
    endcase
  end

  always_comb begin
    if (in_pre) begin
      out_char_o = inv_char(pos_q);
    end else begin
      case (head_i.body)
        BODY_CHAR: out_char_o = head_i.chr;
        BODY_INV:  out_char_o = inv_char(pos_q);
        BODY_CODE: out_char_o = code_ch;
        default:   out_char_o = CH_SPACE;
      endcase
    end
  end

  assign take       = pop_i && head_valid_i;
  assign head_pop_o = take && run_last_o;

  always_comb begin
    pos_d      = pos_q;
    pre_done_d = pre_done_q;
    if (take) begin
      if (run_last_o) begin
        pos_d      = '0;
        pre_done_d = 1'b0;
      end else if (seg_last) begin
        pos_d      = '0;
        pre_done_d = 1'b1;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      pre_done_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      pre_done_q <= pre_done_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_text_sanitizer_top.sv =====
// ----------------------------------------------------------------------------
// utf8_text_sanitizer_top
// Byte stream in, printable ASCII characters out, UTF-8 shown as [U+XXXX].
//
//   channel   direction  handshake             payload
//   input     in         push / full           in_byte_i, end_of_string_i
//   result    out        empty / pop           out_char_o, run_last_o
//   config    in         cfg_valid_i / ready   cfg_data_i (char_limit)
//
// The decoder takes one byte per cycle while full is low and writes a command
// into a short queue; the expander sends one character per cycle from the
// queue head while pop is high. An escape holds the expander for its whole
// bracketed text, so full rises once the queue fills behind it.
// Reset takes effect at once, with no clearing pass; char_limit returns to 160.
// Either side may stall without blocking the other until the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_sanitizer_top
  import uts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_string_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      out_char_o,
  output logic            run_last_o
);

  logic     accept;
  logic     cmd_valid;
  uts_cmd_t cmd;
  logic     head_valid;
  uts_cmd_t head;
  logic     head_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;
  assign empty       = !head_valid;

  uts_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  uts_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  uts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .pop_i        (pop),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/uts_checker.sv =====
// ----------------------------------------------------------------------------
// uts_checker
// Port-level checks of the sanitizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_text_sanitizer_top_macros.svh"

module uts_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [6:0] out_char_o,
  input wire logic       run_last_o
);

  // only printable characters leave the block
  `UTS_ASSERT_NOW(a_printable, !empty, (out_char_o >= 7'd32) && (out_char_o <= 7'd126))

  // a waiting word holds until taken
  `UTS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_char_o) && $stable(run_last_o))

  // no word appears without a byte taken
  `UTS_ASSERT_NEXT(a_no_invent, empty && !(push && !full), empty)

  // a full queue always has a word to offer
  `UTS_ASSERT_NOW(a_full_not_empty, full, !empty)

endmodule

bind utf8_text_sanitizer_top uts_checker u_uts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_char_o (out_char_o),
  .run_last_o (run_last_o)
);

`default_nettype wire
